// File: rtl/msma_pkg.sv
package msma_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int CHANNEL_BITS = 3;
    localparam int MAX_REPORTED = 8;

    localparam int DEF_CHANNELS = 8;
    localparam int DEF_WINDOW = 16;
    localparam int DEF_SELECTS = 8;

    // A reciprocal of an N-bit divisor range needs N+2 bits for a 12-bit dividend.
    localparam int RECIP_BITS = SAMPLE_BITS + 2;
    localparam int PROD_BITS = SAMPLE_BITS + RECIP_BITS;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] channel;
        logic [SAMPLE_BITS-1:0]  sample;
        logic                    end_of_scan;
    } in_item_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_channel;
        logic [SAMPLE_BITS-1:0]  average;
        logic                    last;
    } out_item_t;

    typedef enum logic [0:0] {
        DIV_SELECTS = 1'b0,
        DIV_WINDOW  = 1'b1
    } div_sel_t;

endpackage

// File: rtl/msma_recip_div.sv
module msma_recip_div
    import msma_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW,
    parameter int SELECTS_PER_CHANNEL = DEF_SELECTS
)
(
    input  div_sel_t               sel,
    input  logic [SAMPLE_BITS-1:0] dividend,
    output logic [SAMPLE_BITS-1:0] quotient
);

    // Rounded-up reciprocal with a shift of width plus log2 of the divisor is
    // exact for every dividend of SAMPLE_BITS bits.
    localparam int WIN_SH = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SEL_SH = SAMPLE_BITS + $clog2(SELECTS_PER_CHANNEL);
    localparam longint WIN_M =
        ((longint'(1) << WIN_SH) + longint'(WINDOW) - 1) / longint'(WINDOW);
    localparam longint SEL_M =
        ((longint'(1) << SEL_SH) + longint'(SELECTS_PER_CHANNEL) - 1)
        / longint'(SELECTS_PER_CHANNEL);
    localparam logic [RECIP_BITS-1:0] WIN_RECIP = RECIP_BITS'(WIN_M);
    localparam logic [RECIP_BITS-1:0] SEL_RECIP = RECIP_BITS'(SEL_M);

    logic [RECIP_BITS-1:0] recip;
    logic [PROD_BITS-1:0]  product;

    always_comb
    begin
        unique case (sel)
            DIV_WINDOW:  recip = WIN_RECIP;
            DIV_SELECTS: recip = SEL_RECIP;
        endcase
    end

    assign product = PROD_BITS'(dividend) * PROD_BITS'(recip);

    always_comb
    begin
        unique case (sel)
            DIV_WINDOW:  quotient = SAMPLE_BITS'(product >> WIN_SH);
            DIV_SELECTS: quotient = SAMPLE_BITS'(product >> SEL_SH);
        endcase
    end

endmodule

// File: rtl/multichannel_scan_moving_average_top.sv
// A conversion without end of scan only updates its accumulator, then the block is ready.
// A conversion with end of scan also walks every channel: each channel goes
// through the ring read, the old-value division and the new-value division on the
// one shared reciprocal multiplier. A reported average that waits on result_ready
// stalls the walk. The first average is registered in channel 0's new-value step.
// Reset clears the sequencer, slot pointer and valid bits at once; no clearing pass.
module multichannel_scan_moving_average_top
    import msma_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int WINDOW = DEF_WINDOW,
    parameter int SELECTS_PER_CHANNEL = DEF_SELECTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RING_AW = PTR_W + CH_W;
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int REPORTED = (CHANNELS < MAX_REPORTED) ? CHANNELS : MAX_REPORTED;
    localparam logic [CH_W-1:0] IDX_LAST = CH_W'(CHANNELS - 1);
    localparam logic [CH_W-1:0] REPORT_LAST = CH_W'(REPORTED - 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_CRD  = 5'b00100,
        S_COLD = 5'b01000,
        S_CNEW = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CH_W-1:0]         idx_reg, idx_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic                    full_reg, full_next;
    logic [CHANNELS-1:0]     acc_valid_reg, acc_valid_next;
    logic [CHANNELS-1:0]     avg_valid_reg, avg_valid_next;
    logic                    result_valid_reg, result_valid_next;

    logic [CHANNEL_BITS-1:0] ch_reg, ch_next;
    logic [SAMPLE_BITS-1:0]  sample_reg, sample_next;
    logic                    eos_reg, eos_next;
    logic [SAMPLE_BITS-1:0]  avg_tmp_reg, avg_tmp_next;
    logic [SAMPLE_BITS-1:0]  new_val_reg, new_val_next;
    out_item_t               result_reg, result_next;

    logic [SAMPLE_BITS-1:0]  acc_mem [CHANNELS];
    logic [SAMPLE_BITS-1:0]  avg_mem [CHANNELS];
    logic [SAMPLE_BITS-1:0]  ring_mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0]  acc_rd_reg;
    logic [SAMPLE_BITS-1:0]  avg_rd_reg;
    logic [SAMPLE_BITS-1:0]  ring_rd_reg;

    logic [CH_W-1:0]         acc_rd_addr;
    logic [CH_W-1:0]         ch_addr;
    logic [RING_AW-1:0]      ring_addr;
    logic                    acc_we, avg_we, ring_we;
    logic [SAMPLE_BITS-1:0]  acc_wdata, avg_wdata, ring_wdata;

    div_sel_t                div_sel;
    logic [SAMPLE_BITS-1:0]  div_in, div_q;

    logic                    ch_in_range;
    logic                    report;
    logic                    out_free;
    logic [SAMPLE_BITS:0]    acc_sum;
    logic [SAMPLE_BITS-1:0]  acc_base;
    logic [SAMPLE_BITS-1:0]  avg_old;

    msma_recip_div #(
        .WINDOW              (WINDOW),
        .SELECTS_PER_CHANNEL (SELECTS_PER_CHANNEL)
    ) u_div (
        .sel      (div_sel),
        .dividend (div_in),
        .quotient (div_q)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    assign ch_addr = CH_W'(ch_reg);
    assign ch_in_range = int'(ch_reg) < CHANNELS;
    assign acc_rd_addr = (state_reg == S_IDLE) ? CH_W'(item.channel) : idx_reg;
    assign ring_addr = {ptr_reg, idx_reg};
    assign report = int'(idx_reg) < REPORTED;
    assign out_free = !result_valid_reg || result_ready;

    assign acc_base = acc_valid_reg[ch_addr] ? acc_rd_reg : '0;
    assign acc_sum = {1'b0, acc_base} + {1'b0, div_q};
    assign avg_old = avg_valid_reg[idx_reg] ? avg_rd_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        ptr_next = ptr_reg;
        full_next = full_reg;
        acc_valid_next = acc_valid_reg;
        avg_valid_next = avg_valid_reg;
        result_valid_next = result_valid_reg && !result_ready;
        ch_next = ch_reg;
        sample_next = sample_reg;
        eos_next = eos_reg;
        avg_tmp_next = avg_tmp_reg;
        new_val_next = new_val_reg;
        result_next = result_reg;
        div_sel = DIV_SELECTS;
        div_in = '0;
        acc_we = 1'b0;
        acc_wdata = acc_sum[SAMPLE_BITS] ? '1 : acc_sum[SAMPLE_BITS-1:0];
        avg_we = 1'b0;
        avg_wdata = avg_tmp_reg + div_q;
        ring_we = 1'b0;
        ring_wdata = acc_valid_reg[idx_reg] ? acc_rd_reg : '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ch_next = item.channel;
                    sample_next = item.sample;
                    eos_next = item.end_of_scan;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                div_sel = DIV_SELECTS;
                div_in = sample_reg;
                if (ch_in_range)
                begin
                    acc_we = 1'b1;
                    acc_valid_next[ch_addr] = 1'b1;
                end
                if (eos_reg)
                begin
                    ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                    idx_next = '0;
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CRD:
            begin
                state_next = S_COLD;
            end
            S_COLD:
            begin
                // The slot holds real data only once the ring has gone all the way round.
                div_sel = DIV_WINDOW;
                div_in = full_reg ? ring_rd_reg : '0;
                avg_tmp_next = avg_old - div_q;
                new_val_next = ring_wdata;
                ring_we = 1'b1;
                acc_valid_next[idx_reg] = 1'b0;
                state_next = S_CNEW;
            end
            S_CNEW:
            begin
                div_sel = DIV_WINDOW;
                div_in = new_val_reg;
                if (!report || out_free)
                begin
                    avg_we = 1'b1;
                    avg_valid_next[idx_reg] = 1'b1;
                    if (report)
                    begin
                        result_valid_next = 1'b1;
                        result_next.out_channel = CHANNEL_BITS'(idx_reg);
                        result_next.average = avg_wdata;
                        result_next.last = (idx_reg == REPORT_LAST);
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        if (ptr_reg == '0)
                        begin
                            full_next = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_CRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            ptr_reg <= '0;
            full_reg <= 1'b0;
            acc_valid_reg <= '0;
            avg_valid_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            ptr_reg <= ptr_next;
            full_reg <= full_next;
            acc_valid_reg <= acc_valid_next;
            avg_valid_reg <= avg_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        sample_reg <= sample_next;
        eos_reg <= eos_next;
        avg_tmp_reg <= avg_tmp_next;
        new_val_reg <= new_val_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[ch_addr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (avg_we)
        begin
            avg_mem[idx_reg] <= avg_wdata;
        end
        avg_rd_reg <= avg_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_addr] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[ring_addr];
    end

endmodule
